>>> rtl/qte_pkg.sv
// ---------------------------------------------------------------------------
// qte_pkg
// shared types and constants for the quaternion to euler angles block
// ---------------------------------------------------------------------------
package qte_pkg;

    localparam int CW = 16;
    localparam int AW = 16;
    localparam int FRAC_BITS = 30;
    localparam int ZW = 34;
    localparam int VW = 40;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
    localparam logic signed [VW-1:0] ONE_FIX = VW'(64'sd1073741824);

    typedef struct packed {
        logic signed [CW-1:0] quat_w;
        logic signed [CW-1:0] quat_x;
        logic signed [CW-1:0] quat_y;
        logic signed [CW-1:0] quat_z;
    } quat_word_t;

    typedef struct packed {
        logic signed [AW-1:0] first_angle;
        logic signed [AW-1:0] middle_angle;
        logic signed [AW-1:0] last_angle;
        logic                 gimbal_clamped;
    } euler_word_t;

    // one cordic lane: x, y, angle accumulator and a flag for a zero input vector
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } lane_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0: r = ZW'(64'sd536870912);
            5'd1: r = ZW'(64'sd316933406);
            5'd2: r = ZW'(64'sd167458907);
            5'd3: r = ZW'(64'sd85004756);
            5'd4: r = ZW'(64'sd42667331);
            5'd5: r = ZW'(64'sd21354465);
            5'd6: r = ZW'(64'sd10679838);
            5'd7: r = ZW'(64'sd5340245);
            5'd8: r = ZW'(64'sd2670163);
            5'd9: r = ZW'(64'sd1335087);
            5'd10: r = ZW'(64'sd667544);
            5'd11: r = ZW'(64'sd333772);
            5'd12: r = ZW'(64'sd166886);
            5'd13: r = ZW'(64'sd83443);
            5'd14: r = ZW'(64'sd41722);
            5'd15: r = ZW'(64'sd20861);
            5'd16: r = ZW'(64'sd10430);
            5'd17: r = ZW'(64'sd5215);
            5'd18: r = ZW'(64'sd2608);
            5'd19: r = ZW'(64'sd1304);
            5'd20: r = ZW'(64'sd652);
            5'd21: r = ZW'(64'sd326);
            5'd22: r = ZW'(64'sd163);
            5'd23: r = ZW'(64'sd81);
            5'd24: r = ZW'(64'sd41);
            5'd25: r = ZW'(64'sd20);
            5'd26: r = ZW'(64'sd10);
            5'd27: r = ZW'(64'sd5);
            5'd28: r = ZW'(64'sd3);
            5'd29: r = ZW'(64'sd1);
            5'd30: r = ZW'(64'sd1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // atan2 pre-rotation into the right half plane
    function automatic lane_t lane_init(input logic signed [VW-1:0] y,
                                        input logic signed [VW-1:0] x);
        lane_t r;
        r.zero = (x == '0) && (y == '0);
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                r.x = y;
                r.y = -x;
                r.z = QUARTER_TURN;
            end
            else
            begin
                r.x = -y;
                r.y = x;
                r.z = -QUARTER_TURN;
            end
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] to_angle(input lane_t l);
        logic signed [ZW-1:0] r;
        r = l.zero ? '0 : l.z;
        r = r + ZW'(64'sd1 <<< (31 - AW));
        return AW'(r >>> (32 - AW));
    endfunction

endpackage

>>> rtl/qte_cell.sv
// ---------------------------------------------------------------------------
// qte_cell
// one cordic vectoring micro-rotation on three lanes with a carried word
// ---------------------------------------------------------------------------
module qte_cell
    import qte_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  lane_t [2:0] in_lane,
    input  logic        in_flag,
    input  logic        in_clamp_sign,
    output logic        out_valid,
    output lane_t [2:0] out_lane,
    output logic        out_flag,
    output logic        out_clamp_sign
);

    localparam logic [4:0] SHIFT = 5'(STAGE % 32);

    logic  valid_reg;
    lane_t [2:0] lane_reg;
    lane_t [2:0] lane_next;
    logic  flag_reg;
    logic  sign_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_next[k] = in_lane[k];
            if (in_lane[k].y >= 0)
            begin
                lane_next[k].x = in_lane[k].x + (in_lane[k].y >>> SHIFT);
                lane_next[k].y = in_lane[k].y - (in_lane[k].x >>> SHIFT);
                lane_next[k].z = in_lane[k].z + atan_entry(SHIFT);
            end
            else
            begin
                lane_next[k].x = in_lane[k].x - (in_lane[k].y >>> SHIFT);
                lane_next[k].y = in_lane[k].y + (in_lane[k].x >>> SHIFT);
                lane_next[k].z = in_lane[k].z - atan_entry(SHIFT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        flag_reg <= in_flag;
        sign_reg <= in_clamp_sign;
    end

    assign out_valid      = valid_reg;
    assign out_lane       = lane_reg;
    assign out_flag       = flag_reg;
    assign out_clamp_sign = sign_reg;

endmodule

>>> rtl/qte_front.sv
// ---------------------------------------------------------------------------
// qte_front
// products, sums, clamp test and square root stepping ahead of the cordic row
// ---------------------------------------------------------------------------
module qte_front
    import qte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  quat_word_t  in_word,
    input  logic        mode,
    output logic        out_valid,
    output lane_t [2:0] out_lane,
    output logic        out_flag,
    output logic        out_clamp_sign
);

    localparam int RW = 62;
    localparam int SQ_STEPS = 31;

    // stage 1: nine products, the tenth slot held at zero
    logic                 v1_reg;
    logic signed [31:0]   p_reg [10];
    logic                 m1_reg;
    logic signed [31:0]   p_next [10];

    always_comb
    begin
        p_next[0] = in_word.quat_w * in_word.quat_x;
        p_next[1] = in_word.quat_y * in_word.quat_z;
        p_next[2] = in_word.quat_x * in_word.quat_x;
        p_next[3] = in_word.quat_y * in_word.quat_y;
        p_next[4] = in_word.quat_w * in_word.quat_y;
        p_next[5] = in_word.quat_z * in_word.quat_x;
        p_next[6] = in_word.quat_w * in_word.quat_z;
        p_next[7] = in_word.quat_x * in_word.quat_y;
        p_next[8] = in_word.quat_z * in_word.quat_z;
        p_next[9] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        m1_reg <= mode;
    end

    // stage 2: sums with pi/2 angle scale of one = 2^30
    function automatic logic signed [VW-1:0] fx(input logic signed [31:0] p);
        return VW'(p) <<< (FRAC_BITS - 2 * (CW - 1));
    endfunction

    logic                 v2_reg;
    logic signed [VW-1:0] n1_reg, d1_reg, sn_reg, n3_reg, d3_reg;
    logic signed [VW-1:0] n1_next, d1_next, sn_next, n3_next, d3_next;

    always_comb
    begin
        if (!m1_reg)
        begin
            n1_next = (fx(p_reg[0]) + fx(p_reg[1])) <<< 1;
            d1_next = ONE_FIX - ((fx(p_reg[2]) + fx(p_reg[3])) <<< 1);
            sn_next = (fx(p_reg[4]) - fx(p_reg[5])) <<< 1;
            n3_next = (fx(p_reg[6]) + fx(p_reg[7])) <<< 1;
            d3_next = ONE_FIX - ((fx(p_reg[3]) + fx(p_reg[8])) <<< 1);
        end
        else
        begin
            n1_next = (fx(p_reg[4]) + fx(p_reg[5])) <<< 1;
            d1_next = ONE_FIX - ((fx(p_reg[3]) + fx(p_reg[2])) <<< 1);
            sn_next = (fx(p_reg[6]) - fx(p_reg[7])) <<< 1;
            n3_next = (fx(p_reg[0]) + fx(p_reg[1])) <<< 1;
            d3_next = ONE_FIX - ((fx(p_reg[2]) + fx(p_reg[8])) <<< 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        n1_reg <= n1_next + fx(p_reg[9]);
        d1_reg <= d1_next;
        sn_reg <= sn_next;
        n3_reg <= n3_next;
        d3_reg <= d3_next;
    end

    // stage 3: clamp test, 31-bit magnitude of the middle sine, zeroed when clamped
    logic                 v3_reg;
    logic                 flag3_reg, sign3_reg;
    logic signed [VW-1:0] n1_3_reg, d1_3_reg, sn3_reg, n3_3_reg, d3_3_reg;
    logic [30:0]          mag_reg;
    logic [30:0]          mag_next;
    logic                 flag_next;

    always_comb
    begin
        flag_next = (sn_reg >= ONE_FIX) || (sn_reg <= -ONE_FIX);
        mag_next  = sn_reg[VW-1] ? 31'(-sn_reg) : 31'(sn_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        flag3_reg <= flag_next;
        sign3_reg <= sn_reg[VW-1];
        mag_reg   <= flag_next ? '0 : mag_next;
        n1_3_reg  <= n1_reg;
        d1_3_reg  <= d1_reg;
        sn3_reg   <= sn_reg;
        n3_3_reg  <= n3_reg;
        d3_3_reg  <= d3_reg;
    end

    // stage 4: square, remainder
    logic                 v4_reg;
    logic                 flag4_reg, sign4_reg;
    logic signed [VW-1:0] n1_4_reg, d1_4_reg, sn4_reg, n3_4_reg, d3_4_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        sq_next;

    assign sq_next = RW'(mag_reg) * RW'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= (RW'(1) << (2 * FRAC_BITS)) - sq_next;
        flag4_reg <= flag3_reg;
        sign4_reg <= sign3_reg;
        n1_4_reg  <= n1_3_reg;
        d1_4_reg  <= d1_3_reg;
        sn4_reg   <= sn3_reg;
        n3_4_reg  <= n3_3_reg;
        d3_4_reg  <= d3_3_reg;
    end

    // square root, one result bit per stage
    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [RW-1:0]        res;
        logic                 flag;
        logic                 sign;
        logic signed [VW-1:0] n1, d1, sn, n3, d3;
    } sq_t;

    function automatic sq_t sqrt_step(input sq_t s, input int g);
        sq_t           r;
        logic [RW-1:0] b;
        b = RW'(1) << (2 * (SQ_STEPS - 1 - g));
        r = s;
        if (s.rem >= s.res + b)
        begin
            r.rem = s.rem - (s.res + b);
            r.res = (s.res >> 1) + b;
        end
        else
        begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    sq_t  sqrt_head;
    sq_t  sqrt_reg       [SQ_STEPS];
    sq_t  sqrt_next      [SQ_STEPS];
    logic sqrt_valid_reg [SQ_STEPS];

    always_comb
    begin
        sqrt_head.rem  = rem_reg;
        sqrt_head.res  = '0;
        sqrt_head.flag = flag4_reg;
        sqrt_head.sign = sign4_reg;
        sqrt_head.n1   = n1_4_reg;
        sqrt_head.d1   = d1_4_reg;
        sqrt_head.sn   = sn4_reg;
        sqrt_head.n3   = n3_4_reg;
        sqrt_head.d3   = d3_4_reg;
    end

    always_comb
    begin
        sqrt_next[0] = sqrt_step(sqrt_head, 0);
        for (int g = 1; g < SQ_STEPS; g++)
            sqrt_next[g] = sqrt_step(sqrt_reg[g-1], g);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < SQ_STEPS; g++)
                sqrt_valid_reg[g] <= 1'b0;
        end
        else
        begin
            sqrt_valid_reg[0] <= v4_reg;
            for (int g = 1; g < SQ_STEPS; g++)
                sqrt_valid_reg[g] <= sqrt_valid_reg[g-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
    end

    // lane setup
    logic  v5_reg;
    lane_t [2:0] lane_reg;
    logic  flag5_reg, sign5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= sqrt_valid_reg[SQ_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        lane_reg[0] <= lane_init(sqrt_reg[SQ_STEPS-1].n1, sqrt_reg[SQ_STEPS-1].d1);
        lane_reg[1] <= lane_init(sqrt_reg[SQ_STEPS-1].sn, VW'(sqrt_reg[SQ_STEPS-1].res));
        lane_reg[2] <= lane_init(sqrt_reg[SQ_STEPS-1].n3, sqrt_reg[SQ_STEPS-1].d3);
        flag5_reg   <= sqrt_reg[SQ_STEPS-1].flag;
        sign5_reg   <= sqrt_reg[SQ_STEPS-1].sign;
    end

    assign out_valid      = v5_reg;
    assign out_lane       = lane_reg;
    assign out_flag       = flag5_reg;
    assign out_clamp_sign = sign5_reg;

endmodule

>>> rtl/quaternion_to_euler_angles.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles
// unit quaternion to three euler angles through a row of cordic cells
// ---------------------------------------------------------------------------
// One word enters every cycle; busy is never raised. Each word passes
// through the product, sum, clamp and square stages (4), the 31-step
// square root row of the middle sine, the lane setup, the cordic cell row
// and the output register. result_valid lasts one cycle and cannot be held
// off. Write sequence_mode only while no word is in flight.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  quat_word_t  quat,
    output logic        result_valid,
    output euler_word_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic        v_chain    [CORDIC_STAGES+1];
    lane_t [2:0] lane_chain [CORDIC_STAGES+1];
    logic        f_chain    [CORDIC_STAGES+1];
    logic        s_chain    [CORDIC_STAGES+1];

    qte_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start),
        .in_word        (quat),
        .mode           (mode_reg),
        .out_valid      (v_chain[0]),
        .out_lane       (lane_chain[0]),
        .out_flag       (f_chain[0]),
        .out_clamp_sign (s_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        qte_cell #(.STAGE(g)) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .in_valid       (v_chain[g]),
            .in_lane        (lane_chain[g]),
            .in_flag        (f_chain[g]),
            .in_clamp_sign  (s_chain[g]),
            .out_valid      (v_chain[g+1]),
            .out_lane       (lane_chain[g+1]),
            .out_flag       (f_chain[g+1]),
            .out_clamp_sign (s_chain[g+1])
        );
    end

    logic        rv_reg;
    euler_word_t res_reg;
    euler_word_t res_next;
    lane_t       mid_lane;

    always_comb
    begin
        mid_lane = lane_chain[CORDIC_STAGES][1];
        if (f_chain[CORDIC_STAGES])
        begin
            mid_lane.zero = 1'b0;
            mid_lane.z = s_chain[CORDIC_STAGES] ? -QUARTER_TURN : QUARTER_TURN;
        end
        res_next.first_angle    = to_angle(lane_chain[CORDIC_STAGES][0]);
        res_next.middle_angle   = to_angle(mid_lane);
        res_next.last_angle     = to_angle(lane_chain[CORDIC_STAGES][2]);
        res_next.gimbal_clamped = f_chain[CORDIC_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= v_chain[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

>>> rtl/qte_checker.sv
// ---------------------------------------------------------------------------
// qte_checker
// port level checks on the quaternion to euler angles block
// ---------------------------------------------------------------------------
module qte_checker
    import qte_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        result_valid,
    input euler_word_t result,
    input logic        cfg_ready
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg not ready");

    a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.middle_angle <= AW'(16384))
                      && (result.middle_angle >= -AW'(16384)))
        else $error("middle angle out of range");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.gimbal_clamped) |->
            (result.middle_angle == AW'(16384) || result.middle_angle == -AW'(16384)))
        else $error("clamped angle wrong");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_ready    (cfg_ready)
);

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// quaternion to euler angles: directed and random quaternions in both
// sequence modes, checked word by word against a bit-true cordic predictor
// ---------------------------------------------------------------------------
module testbench
    import qte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam longint UNIT = 64'sd1 << 30;
    localparam longint RIGHT_ANGLE = 64'sd1 << 30;
    localparam longint ARCTAN_STEP [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    quat_word_t  quat;
    logic        result_valid;
    euler_word_t result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    quat_word_t  pending_quats[$];
    euler_word_t expected_angles[$];
    logic        sequence_mode;
    logic        mode_request;
    logic        mode_value;
    int          idle_pct;
    bit          failed;

    quaternion_to_euler_angles dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .quat         (quat),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    function automatic longint cordic_atan2(longint y, longint x);
        longint a;
        longint t;
        longint dx;
        longint dy;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                a = RIGHT_ANGLE;
            end
            else
            begin
                x = -y;
                y = t;
                a = -RIGHT_ANGLE;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + ARCTAN_STEP[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                a = a - ARCTAN_STEP[i];
            end
        end
        return a;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [AW-1:0] binary_angle(longint a);
        longint r;
        r = (a + 64'sd32768) >>> 16;
        return r[AW-1:0];
    endfunction

    function automatic euler_word_t euler_of(quat_word_t q, logic mode);
        euler_word_t e;
        longint w, x, y, z;
        longint n1, d1, sn, n3, d3, mid;
        longint unsigned sq;
        w = q.quat_w;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        e.gimbal_clamped = 1'b0;
        if (!mode)
        begin
            n1 = 2 * (w * x + y * z);
            d1 = UNIT - 2 * (x * x + y * y);
            sn = 2 * (w * y - z * x);
            n3 = 2 * (w * z + x * y);
            d3 = UNIT - 2 * (y * y + z * z);
        end
        else
        begin
            n1 = 2 * (w * y + z * x);
            d1 = UNIT - 2 * (y * y + x * x);
            sn = 2 * (w * z - x * y);
            n3 = 2 * (w * x + y * z);
            d3 = UNIT - 2 * (x * x + z * z);
        end
        if (sn >= UNIT)
        begin
            mid = RIGHT_ANGLE;
            e.gimbal_clamped = 1'b1;
        end
        else if (sn <= -UNIT)
        begin
            mid = -RIGHT_ANGLE;
            e.gimbal_clamped = 1'b1;
        end
        else
        begin
            sq = longint'(sn < 0 ? -sn : sn);
            mid = cordic_atan2(sn, root_floor((64'd1 << 60) - sq * sq));
        end
        e.first_angle = binary_angle(cordic_atan2(n1, d1));
        e.middle_angle = binary_angle(mid);
        e.last_angle = binary_angle(cordic_atan2(n3, d3));
        return e;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver: one word per handshake, random idle cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            quat <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_angles.insert(expected_angles.size(),
                                       euler_of(quat, sequence_mode));
            if (!start || !busy)
            begin
                if (pending_quats.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    quat <= pending_quats.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // mode register write channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data <= 1'b0;
            sequence_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            sequence_mode <= cfg_data;
            mode_request <= 1'b0;
        end
        else if (!cfg_valid && mode_request)
        begin
            cfg_valid <= 1'b1;
            cfg_data <= mode_value;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        euler_word_t e;
        if (rst_n && result_valid)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("unexpected result word %h", result);
                failed = 1'b1;
            end
            else
            begin
                e = expected_angles.pop_front();
                if (result.first_angle !== e.first_angle)
                begin
                    $error("first_angle expected %0d got %0d", e.first_angle,
                           result.first_angle);
                    failed = 1'b1;
                end
                if (result.middle_angle !== e.middle_angle)
                begin
                    $error("middle_angle expected %0d got %0d", e.middle_angle,
                           result.middle_angle);
                    failed = 1'b1;
                end
                if (result.last_angle !== e.last_angle)
                begin
                    $error("last_angle expected %0d got %0d", e.last_angle,
                           result.last_angle);
                    failed = 1'b1;
                end
                if (result.gimbal_clamped !== e.gimbal_clamped)
                begin
                    $error("gimbal_clamped expected %0d got %0d", e.gimbal_clamped,
                           result.gimbal_clamped);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic push_quat(int w, int x, int y, int z);
        quat_word_t q;
        q.quat_w = w[CW-1:0];
        q.quat_x = x[CW-1:0];
        q.quat_y = y[CW-1:0];
        q.quat_z = z[CW-1:0];
        pending_quats.insert(pending_quats.size(), q);
    endtask

    task automatic drain();
        while (pending_quats.size() > 0 || start || expected_angles.size() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        mode_value = m;
        mode_request = 1'b1;
        while (mode_request)
            @(posedge clk);
    endtask

    task automatic push_directed();
        push_quat(0, 0, 0, 0);
        push_quat(32767, 0, 0, 0);
        push_quat(-32768, 0, 0, 0);
        push_quat(0, 32767, 0, 0);
        push_quat(0, 0, 32767, 0);
        push_quat(0, 0, 0, 32767);
        push_quat(-32768, -32768, -32768, -32768);
        push_quat(32767, 32767, 32767, 32767);
        push_quat(32767, -32768, 32767, -32768);
        push_quat(0, 16384, 16384, 0);
        push_quat(0, 16384, 0, 16384);
        push_quat(0, 0, 16384, 16384);
        push_quat(23170, 0, 23170, 0);
        push_quat(23171, 0, 23171, 0);
        push_quat(23171, 0, -23171, 0);
        push_quat(23171, 0, 0, 23171);
        push_quat(23171, 0, 0, -23171);
        push_quat(16384, 16384, 16384, 16384);
        push_quat(16384, -16384, 16384, -16384);
        push_quat(1, -1, 1, -1);
    endtask

    task automatic push_random(int n);
        int c[4];
        int s;
        for (int i = 0; i < n; i++)
        begin
            s = $urandom_range(9);
            for (int k = 0; k < 4; k++)
            begin
                if (s < 4)
                    c[k] = $urandom_range(23170) - 11585;
                else if (s < 8)
                    c[k] = $urandom_range(65535) - 32768;
                else
                    c[k] = ($urandom_range(1) == 1) ? 32767 : -32768;
            end
            push_quat(c[0], c[1], c[2], c[3]);
        end
    endtask

    initial
    begin
        int pct[4];
        pct = '{0, 52, 52, 35};
        failed = 1'b0;
        mode_request = 1'b0;
        mode_value = 1'b0;
        idle_pct = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int m = 0; m < 2; m++)
        begin
            write_mode(m[0]);
            push_directed();
            drain();
        end
        for (int p = 0; p < 8; p++)
        begin
            idle_pct = pct[p % 4];
            write_mode(p[0]);
            push_random(250);
            drain();
        end
        repeat (70) @(posedge clk);
        if (!failed && expected_angles.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
